/* src/sli_pkg.sv */
// ----------------------------------------------------------------------------
// sli_pkg
// Command and status codes and field widths for the sorted insertion list.
// ----------------------------------------------------------------------------
package sli_pkg;

  // field widths fixed by the item format
  localparam int CMD_W  = 2;
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

endpackage

/* src/sli_ram.sv */
// ----------------------------------------------------------------------------
// sli_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/sorted_list_insert_remove.sv */
// ----------------------------------------------------------------------------
// sorted_list_insert_remove
// Bounded ascending list of signed 32-bit values held in one entry RAM.
// ----------------------------------------------------------------------------
//   channel | direction | ports                                   | flow
//   in      | input     | in_command, in_value, in_position       | valid/stall
//   out     | output    | out_status, out_element, out_count      | valid/stall
//
// One item is in work at a time; in_stall is high from the transfer until
// its result is placed in the output register.
// Insert moves each entry greater than the value up one place, one entry at a
// time; remove moves each entry after the position down one place; read
// fetches one entry; refused or ignored items go straight to the result state.
// The single read port and its registered read set the pace of each item.
// Reset clears the fill count and the handshake state; entries need no clear.
// A stalled result holds in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove
  import sli_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]         in_position,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_element,
  output logic [CNT_W-1:0]         out_count
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PCW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_GET_RD,
    S_GET_CAP,
    S_SH_RD,
    S_SH_WR,
    S_OUT
  } state_t;

  state_t                     state_r;
  logic [CMD_W-1:0]           cmd_r;
  logic signed [DATA_W-1:0]   val_r;
  logic [AW-1:0]              ptr_r;
  logic [CW-1:0]              cnt_r;
  logic [STAT_W-1:0]          res_status_r;
  logic [DATA_W-1:0]          res_elem_r;
  logic                       out_valid_r;
  logic [STAT_W-1:0]          out_status_r;
  logic [DATA_W-1:0]          out_element_r;
  logic [CNT_W-1:0]           out_count_r;

  logic                       in_xfer;
  logic                       out_load;
  logic [PCW-1:0]             pos_ext;
  logic [PCW-1:0]             cnt_ext;
  logic                       pos_bad;
  logic [AW-1:0]              pos_idx;
  logic                       ptr_last;
  logic                       rd_greater;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [DATA_W-1:0]          wr_data;
  logic                       rd_en;
  logic [DATA_W-1:0]          rd_data;

  // handshake
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // position checks against the current fill
  assign pos_ext    = PCW'(in_position);
  assign cnt_ext    = PCW'(cnt_r);
  assign pos_bad    = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign pos_idx    = AW'(pos_ext - PCW'(1));
  assign ptr_last   = ((CW'(ptr_r) + CW'(1)) == cnt_r);
  assign rd_greater = ($signed(rd_data) > val_r);

  // entry memory access per state
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = val_r;
    rd_en   = 1'b0;
    case (state_r)
      S_INS_RD, S_GET_RD, S_SH_RD: begin
        rd_en = 1'b1;
      end
      S_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r + AW'(1);
        wr_data = rd_greater ? rd_data : val_r;
      end
      S_INS_PUT: begin
        wr_en = 1'b1;
      end
      S_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r - AW'(1);
        wr_data = rd_data;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  sli_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  // sequencer, fill count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            cmd_r      <= in_command;
            val_r      <= in_value;
            res_elem_r <= '0;
            case (in_command)
              CMD_INSERT: begin
                if (cnt_r == CAP_CNT) begin
                  res_status_r <= ST_FULL;
                  state_r      <= S_OUT;
                end else if (cnt_r == '0) begin
                  res_status_r <= ST_OK;
                  ptr_r        <= '0;
                  state_r      <= S_INS_PUT;
                end else begin
                  res_status_r <= ST_OK;
                  ptr_r        <= AW'(cnt_r - CW'(1));
                  state_r      <= S_INS_RD;
                end
              end
              CMD_REMOVE, CMD_READ: begin
                if (cnt_r == '0) begin
                  res_status_r <= ST_EMPTY;
                  state_r      <= S_OUT;
                end else if (pos_bad) begin
                  res_status_r <= ST_BADPOS;
                  state_r      <= S_OUT;
                end else begin
                  res_status_r <= ST_OK;
                  ptr_r        <= pos_idx;
                  state_r      <= S_GET_RD;
                end
              end
              default: begin
                res_status_r <= ST_OK;
                state_r      <= S_OUT;
              end
            endcase
          end
        end
        S_INS_RD: begin
          state_r <= S_INS_CMP;
        end
        // greater entries move up one place; stop at the first not greater
        S_INS_CMP: begin
          if (rd_greater) begin
            if (ptr_r == '0) begin
              state_r <= S_INS_PUT;
            end else begin
              ptr_r   <= ptr_r - AW'(1);
              state_r <= S_INS_RD;
            end
          end else begin
            cnt_r   <= cnt_r + CW'(1);
            state_r <= S_OUT;
          end
        end
        S_INS_PUT: begin
          cnt_r   <= cnt_r + CW'(1);
          state_r <= S_OUT;
        end
        S_GET_RD: begin
          state_r <= S_GET_CAP;
        end
        S_GET_CAP: begin
          res_elem_r <= rd_data;
          if (cmd_r == CMD_READ) begin
            state_r <= S_OUT;
          end else if (ptr_last) begin
            cnt_r   <= cnt_r - CW'(1);
            state_r <= S_OUT;
          end else begin
            ptr_r   <= ptr_r + AW'(1);
            state_r <= S_SH_RD;
          end
        end
        S_SH_RD: begin
          state_r <= S_SH_WR;
        end
        // close the gap one entry at a time
        S_SH_WR: begin
          if (ptr_last) begin
            cnt_r   <= cnt_r - CW'(1);
            state_r <= S_OUT;
          end else begin
            ptr_r   <= ptr_r + AW'(1);
            state_r <= S_SH_RD;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= res_status_r;
            out_element_r <= res_elem_r;
            out_count_r   <= CNT_W'(cnt_r);
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_count   = out_count_r;

  // fill never passes the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("fill count above capacity");

  // the entry sequencing never reads and writes in one cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("entry read and write in the same cycle");

  // an input transfer always blocks further transfers until the result is out
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input taken while an item is in work");

  // the fill count only moves when an item finishes
  a_cnt_moves_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (state_r == S_OUT))
    else $error("fill count changed mid-item");

  // a result is loaded only from the result state
  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result presented outside the result state");

endmodule

/* verif/sorted_list_insert_remove_tb.sv */
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_tb
// Self-checking bench for the sorted insertion list. A shadow list predicts
// status, element and count for every input transfer; a monitor checks each
// result transfer in order. Stimulus mixes directed corner cases with random
// fill, drain and mixed runs under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_tb
  import sli_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 16;
  localparam int ITEM_TARGET = 1300;
  localparam int REPORT_MAX  = 60;

  // command code the block ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    bit                       wait_idle;
  } list_cmd_t;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] element;
    logic [CNT_W-1:0]         count;
  } list_result_t;

  logic                     clk;
  logic                     rst_n       = 1'b0;
  logic                     in_valid    = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command  = CMD_INSERT;
  logic signed [DATA_W-1:0] in_value    = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic                     out_valid;
  logic                     out_stall   = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_element;
  logic [CNT_W-1:0]         out_count;

  list_cmd_t                pending_cmds[$];
  list_result_t             expected_results[$];
  logic signed [DATA_W-1:0] shadow_list[$];

  int gen_count;
  int inputs_taken;
  int results_seen;
  int error_count;
  int longest_list;
  int status_tally[4];

  sorted_list_insert_remove #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_value   (in_value),
    .in_position(in_position),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_element(out_element),
    .out_count  (out_count)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // shadow list update for one accepted command
  function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [DATA_W-1:0] val,
                                                  input logic [POS_W-1:0] pos);
    list_result_t res;
    int           slot;
    res.status  = ST_OK;
    res.element = '0;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_list.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // first stored element strictly greater keeps equal values in order
          slot = shadow_list.size();
          for (int i = 0; i < shadow_list.size(); i++) begin
            if (shadow_list[i] > val) begin
              slot = i;
              break;
            end
          end
          shadow_list.insert(slot, val);
        end
      end
      CMD_REMOVE, CMD_READ: begin
        // empty takes priority over a bad position
        if (shadow_list.size() == 0) begin
          res.status = ST_EMPTY;
        end else if (pos == 0 || pos > shadow_list.size()) begin
          res.status = ST_BADPOS;
        end else begin
          res.element = shadow_list[pos - 1];
          if (cmd == CMD_REMOVE) begin
            shadow_list.delete(pos - 1);
          end
        end
      end
      default: begin
      end
    endcase
    res.count = CNT_W'(shadow_list.size());
    return res;
  endfunction

  // queue a command, tracking the list length for stimulus shaping
  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] val,
                           input int pos, input bit wait_idle);
    list_cmd_t item;
    item.command   = cmd;
    item.value     = val;
    item.position  = POS_W'(pos);
    item.wait_idle = wait_idle;
    pending_cmds.push_back(item);
    if (cmd == CMD_INSERT && gen_count < CAPACITY) begin
      gen_count++;
    end else if (cmd == CMD_REMOVE && gen_count > 0 && item.position >= 1 &&
                 item.position <= gen_count) begin
      gen_count--;
    end
  endtask

  // values: wide random, small clustered for duplicates, and extremes
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6, 7:       v = $signed(DATA_W'($urandom_range(0, 16))) - 8;
      8: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = '0;
          default: v = -1;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          v = 32'sh7FFF_FFFF - $urandom_range(0, 3);
        end else begin
          v = 32'sh8000_0000 + $urandom_range(0, 3);
        end
      end
    endcase
    return v;
  endfunction

  // positions: mostly in range, some zero, past the end or anything
  function automatic int pick_position(input int n);
    int p;
    case ($urandom_range(0, 9))
      0:       p = 0;
      1:       p = $urandom_range(n + 1, 31);
      2:       p = $urandom_range(0, 31);
      default: p = (n == 0) ? $urandom_range(0, 31) : $urandom_range(1, n);
    endcase
    return p;
  endfunction

  // stimulus, reset and end of run
  initial begin
    int run_len;
    bit first;
    gen_count = 0;

    // directed corners
    queue_cmd(CMD_READ,   '0, 1, 1'b0);
    queue_cmd(CMD_REMOVE, '0, 0, 1'b0);
    queue_cmd(CMD_UNUSED, 32'sh5A5A_5A5A, 31, 1'b0);
    queue_cmd(CMD_INSERT, '0, 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'sh7FFF_FFFF, 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'sh8000_0000, 0, 1'b0);
    queue_cmd(CMD_INSERT, -1, 0, 1'b0);
    queue_cmd(CMD_INSERT, '0, 31, 1'b0);
    queue_cmd(CMD_INSERT, 1, 0, 1'b0);
    queue_cmd(CMD_READ,   '0, 0, 1'b0);
    queue_cmd(CMD_READ,   '0, 7, 1'b0);
    queue_cmd(CMD_REMOVE, '0, 31, 1'b0);
    queue_cmd(CMD_READ,   '0, 1, 1'b0);
    queue_cmd(CMD_READ,   '0, 6, 1'b0);
    queue_cmd(CMD_READ,   '0, 3, 1'b0);
    queue_cmd(CMD_REMOVE, '0, 6, 1'b0);
    queue_cmd(CMD_REMOVE, '0, 1, 1'b0);
    queue_cmd(CMD_REMOVE, '0, 2, 1'b0);
    queue_cmd(CMD_UNUSED, -1, 0, 1'b0);
    queue_cmd(CMD_READ,   '0, 3, 1'b1);

    // random runs
    first = 1'b1;
    while (pending_cmds.size() < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // fill to capacity, then inserts that must be refused
          queue_cmd(CMD_INSERT, pick_value(), 0, first || ($urandom_range(0, 2) == 0));
          while (gen_count < CAPACITY) begin
            queue_cmd(CMD_INSERT, pick_value(), $urandom_range(0, 31), 1'b0);
          end
          repeat ($urandom_range(1, 3)) begin
            queue_cmd(CMD_INSERT, pick_value(), 0, 1'b0);
          end
        end
        2: begin
          // drain with reads mixed in, then hit the empty list
          while (gen_count > 0) begin
            if ($urandom_range(0, 3) == 0) begin
              queue_cmd(CMD_READ, pick_value(), $urandom_range(1, gen_count), 1'b0);
            end
            queue_cmd(CMD_REMOVE, pick_value(), $urandom_range(1, gen_count), 1'b0);
          end
          repeat ($urandom_range(1, 2)) begin
            queue_cmd(($urandom_range(0, 1) == 0) ? CMD_READ : CMD_REMOVE, '0,
                      $urandom_range(0, 31), 1'b0);
          end
        end
        3: begin
          // noise over every field
          repeat ($urandom_range(1, 6)) begin
            queue_cmd(CMD_W'($urandom_range(0, 3)), $urandom, $urandom_range(0, 31), 1'b0);
          end
        end
        default: begin
          // mixed traffic
          run_len = $urandom_range(5, 30);
          repeat (run_len) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3: queue_cmd(CMD_INSERT, pick_value(), $urandom_range(0, 31), 1'b0);
              4, 5:       queue_cmd(CMD_REMOVE, pick_value(), pick_position(gen_count), 1'b0);
              6, 7, 8:    queue_cmd(CMD_READ, pick_value(), pick_position(gen_count), 1'b0);
              default:    queue_cmd(CMD_UNUSED, $urandom, $urandom_range(0, 31), 1'b0);
            endcase
          end
        end
      endcase
      first = 1'b0;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all transfers and results, then let the block settle
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);

    $display("covered %0d input transfers and %0d result transfers, list length up to %0d",
             inputs_taken, results_seen, longest_list);
    $display("statuses: %0d ok, %0d full, %0d empty, %0d bad position",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
             status_tally[ST_BADPOS]);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // input driver: bursts with random gaps, optional wait for an idle block
  always @(posedge clk) begin : drive_proc
    list_cmd_t    item;
    list_result_t res;
    int           burst_left;
    int           gap_left;
    logic         next_valid;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      // predict on every accepted transfer
      if (in_valid && !in_stall) begin
        res = apply_list_cmd(in_command, in_value, in_position);
        expected_results.push_back(res);
        inputs_taken++;
        status_tally[res.status]++;
        if (shadow_list.size() > longest_list) begin
          longest_list = shadow_list.size();
        end
      end
      next_valid = 1'b0;
      if (in_valid && in_stall) begin
        next_valid = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].wait_idle && expected_results.size() != 0)) begin
        item = pending_cmds.pop_front();
        in_command  <= item.command;
        in_value    <= item.value;
        in_position <= item.position;
        next_valid  = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 3))
            0, 1:    gap_left = 0;
            2:       gap_left = $urandom_range(1, 3);
            default: gap_left = $urandom_range(4, 15);
          endcase
        end else begin
          burst_left--;
        end
      end
      in_valid <= next_valid;
    end
  end

  // output stall: segments of differing density plus long hold-offs
  always @(posedge clk) begin : stall_proc
    int   seg_left;
    int   stall_mode;
    int   hold_left;
    int   next_hold_mark;
    logic stall_next;
    if (!rst_n) begin
      out_stall      <= 1'b0;
      seg_left       = 0;
      stall_mode     = 0;
      hold_left      = 0;
      next_hold_mark = 300;
    end else begin
      if (inputs_taken >= next_hold_mark) begin
        hold_left      = 400;
        next_hold_mark = next_hold_mark + 600;
      end
      if (hold_left != 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (seg_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          seg_left   = $urandom_range(16, 160);
        end else begin
          seg_left--;
        end
        case (stall_mode)
          0:       stall_next = 1'b0;
          1:       stall_next = ($urandom_range(0, 3) == 0);
          2:       stall_next = ($urandom_range(0, 3) != 0);
          default: stall_next = ~out_stall;
        endcase
      end
      out_stall <= stall_next;
    end
  end

  task automatic report_mismatch(input string field, input longint want, input longint got);
    error_count++;
    $error("%s mismatch: expected %0d, got %0d", field, want, got);
  endtask

  // result monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_proc
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX) begin
          $error("result transfer with none expected: status %0d element %0d count %0d",
                 out_status, out_element, out_count);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          report_mismatch("status", want.status, out_status);
        end
        if (out_element !== want.element) begin
          report_mismatch("element", want.element, out_element);
        end
        if (out_count !== want.count) begin
          report_mismatch("count", want.count, out_count);
        end
      end
    end
  end

endmodule
